>>> hw/rtl/arc_pkg.sv
package arc_pkg;

    localparam int ARC_SUM_BITS   = 32;
    localparam int ARC_COUNT_BITS = 16;

    localparam int FLAGS_W = 12;
    localparam int KIND_W  = 4;
    localparam int OPLEN_W = 28;
    localparam int CFG_W   = 16;
    localparam int POS_W   = 29;
    localparam int CLASS_W = 3;

    // CIGAR op kinds
    localparam logic [KIND_W-1:0] KIND_M = 4'd0;
    localparam logic [KIND_W-1:0] KIND_I = 4'd1;
    localparam logic [KIND_W-1:0] KIND_S = 4'd4;
    localparam logic [KIND_W-1:0] KIND_H = 4'd5;

    // SAM flag bits
    localparam int FLAG_UNMAPPED_BIT      = 2;
    localparam int FLAG_MATE_UNMAPPED_BIT = 3;
    localparam int FLAG_SUPPLEMENTARY_BIT = 11;

    // configuration register indexes
    localparam logic REG_READ_LENGTH     = 1'b0;
    localparam logic REG_FULL_MAP_CUTOFF = 1'b1;

    localparam logic [CFG_W-1:0] READ_LENGTH_RST     = 16'd150;
    localparam logic [CFG_W-1:0] FULL_MAP_CUTOFF_RST = 16'd58982;

    // read classes
    localparam logic [CLASS_W-1:0] RCLASS_FULLMAP       = 3'd0;
    localparam logic [CLASS_W-1:0] RCLASS_OTHER         = 3'd1;
    localparam logic [CLASS_W-1:0] RCLASS_CLIPPED       = 3'd2;
    localparam logic [CLASS_W-1:0] RCLASS_UNMAP_MATE_OK = 3'd3;
    localparam logic [CLASS_W-1:0] RCLASS_BOTH_UNMAPPED = 3'd4;

    // clip classes
    localparam logic [CLASS_W-1:0] CCLASS_NONE       = 3'd0;
    localparam logic [CLASS_W-1:0] CCLASS_BOTH_SOFT  = 3'd1;
    localparam logic [CLASS_W-1:0] CCLASS_LEFT_SOFT  = 3'd2;
    localparam logic [CLASS_W-1:0] CCLASS_RIGHT_SOFT = 3'd3;
    localparam logic [CLASS_W-1:0] CCLASS_BOTH_HARD  = 3'd4;
    localparam logic [CLASS_W-1:0] CCLASS_LEFT_HARD  = 3'd5;
    localparam logic [CLASS_W-1:0] CCLASS_RIGHT_HARD = 3'd6;

    // finished read, handed from the accumulator to the classifier
    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [KIND_W-1:0]  head_kind;
        logic [OPLEN_W-1:0] head_len;
        logic [KIND_W-1:0]  tail_kind;
        logic [OPLEN_W-1:0] tail_len;
        logic               single;
        logic               multi;
    } t_snap;

    typedef struct packed {
        logic [POS_W-1:0]   right_len;
        logic [POS_W-1:0]   right_pos;
        logic [POS_W-1:0]   left_len;
        logic               left_pos;
        logic [CLASS_W-1:0] clip_class;
        logic [CLASS_W-1:0] read_class;
    } t_result;

endpackage

>>> hw/rtl/arc_classify.sv
module arc_classify #(
    parameter int SUM_BITS = arc_pkg::ARC_SUM_BITS
) (
    input  arc_pkg::t_snap                  i_snap,
    input  logic [SUM_BITS-1:0]             i_matched,
    input  logic [SUM_BITS-1:0]             i_total,
    input  logic [arc_pkg::CFG_W-1:0]       i_read_length,
    input  logic [arc_pkg::CFG_W-1:0]       i_cutoff,
    output arc_pkg::t_result                o_result
);
    import arc_pkg::*;

    localparam int PROD_W = SUM_BITS + CFG_W;

    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]  w_scaled;
    logic               w_single_m;
    logic               w_clipped;
    logic               w_full;
    logic               w_hard;
    logic               w_head_s, w_head_h, w_tail_s, w_tail_h;
    logic [POS_W-1:0]   w_rl, w_hl, w_tl, w_rpos_both, w_rpos_one;
    localparam logic [POS_W-1:0] NONE = '1;

    assign w_prod   = {{SUM_BITS{1'b0}}, i_cutoff} * {{CFG_W{1'b0}}, i_total};
    assign w_scaled = {i_matched, {CFG_W{1'b0}}};

    assign w_head_s = (i_snap.head_kind == KIND_S);
    assign w_head_h = (i_snap.head_kind == KIND_H);
    assign w_tail_s = (i_snap.tail_kind == KIND_S);
    assign w_tail_h = (i_snap.tail_kind == KIND_H);

    assign w_single_m = i_snap.single && (i_snap.head_kind == KIND_M);

    assign w_rl = {{(POS_W-CFG_W){1'b0}}, i_read_length};
    assign w_hl = {1'b0, i_snap.head_len};
    assign w_tl = {1'b0, i_snap.tail_len};
    assign w_rpos_both = w_rl - w_tl;
    assign w_rpos_one  = w_rl - w_tl - POS_W'(1);

    always_comb begin
        if (w_single_m && (i_snap.head_len == {{(OPLEN_W-CFG_W){1'b0}}, i_read_length})) begin
            w_clipped = 1'b0;
        end else begin
            w_clipped = i_snap.multi && (w_head_s || w_head_h || w_tail_s || w_tail_h);
        end

        priority if (w_single_m &&
                     (i_snap.head_len <= {{(OPLEN_W-CFG_W){1'b0}}, i_read_length})) begin
            w_full = 1'b1;
        end else if (i_total == '0) begin
            w_full = 1'b0;
        end else begin
            w_full = (w_scaled > w_prod);
        end

        w_hard = i_snap.multi && (w_head_h || w_tail_h);

        if (!i_snap.flags[FLAG_UNMAPPED_BIT]) begin
            if (!i_snap.flags[FLAG_SUPPLEMENTARY_BIT]) begin
                o_result.read_class = w_clipped ? RCLASS_CLIPPED
                                    : (w_full ? RCLASS_FULLMAP : RCLASS_OTHER);
            end else begin
                o_result.read_class = w_hard ? RCLASS_CLIPPED : RCLASS_OTHER;
            end
        end else begin
            o_result.read_class = i_snap.flags[FLAG_MATE_UNMAPPED_BIT]
                                ? RCLASS_BOTH_UNMAPPED : RCLASS_UNMAP_MATE_OK;
        end

        o_result.clip_class = CCLASS_NONE;
        o_result.left_pos   = 1'b1;
        o_result.left_len   = NONE;
        o_result.right_pos  = NONE;
        o_result.right_len  = NONE;
        if (i_snap.multi) begin
            priority if (w_head_s && w_tail_s) begin
                o_result.clip_class = CCLASS_BOTH_SOFT;
                o_result.left_pos   = 1'b0;
                o_result.left_len   = w_hl;
                o_result.right_pos  = w_rpos_both;
                o_result.right_len  = w_tl;
            end else if (w_head_s) begin
                o_result.clip_class = CCLASS_LEFT_SOFT;
                o_result.left_pos   = 1'b0;
                o_result.left_len   = w_hl;
            end else if (w_tail_s) begin
                o_result.clip_class = CCLASS_RIGHT_SOFT;
                o_result.right_pos  = w_rpos_one;
                o_result.right_len  = w_tl;
            end else if (w_head_h && w_tail_h) begin
                o_result.clip_class = CCLASS_BOTH_HARD;
                o_result.left_pos   = 1'b0;
                o_result.left_len   = w_hl;
                o_result.right_pos  = w_rpos_both;
                o_result.right_len  = w_tl;
            end else if (w_head_h) begin
                o_result.clip_class = CCLASS_LEFT_HARD;
                o_result.left_pos   = 1'b0;
                o_result.left_len   = w_hl;
            end else if (w_tail_h) begin
                o_result.clip_class = CCLASS_RIGHT_HARD;
                o_result.right_pos  = w_rpos_one;
                o_result.right_len  = w_tl;
            end else begin
                o_result.clip_class = CCLASS_NONE;
            end
        end
    end

endmodule

>>> hw/rtl/aligned_read_classifier.sv
// Channel   Dir  Request contents
// s_axis    in   tdata: record_flags[11:0], op_length[39:12]
//                tuser: op_kind[3:0], first_op[4]; tlast: last_op
// m_axis    out  tdata: read_class, clip_class, left_pos, left_len, right_pos,
//                right_len (lowest bit up), padded to 96 bits
// cfg       in   write enable, register index, 16-bit data
//
// One CIGAR op per cycle while the output is not stalled. Each op updates the running
// sums in the cycle it is accepted; the last op of a read loads a snapshot register,
// and the classifier (one 16 x SUM_BITS multiply and compare) fills the output
// register from it when the output can advance. Synchronous reset clears the sums,
// valids and config to defaults. A stalled output holds the pipe.
module aligned_read_classifier #(
    parameter int SUM_BITS   = arc_pkg::ARC_SUM_BITS,
    parameter int COUNT_BITS = arc_pkg::ARC_COUNT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [39:0]                 i_s_axis_tdata,  // record_flags, op_length
    input  logic [4:0]                  i_s_axis_tuser,  // op_kind, first_op
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // read_class, clip_class, left_pos, left_len, right_pos, right_len
    output logic [95:0]                 o_m_axis_tdata,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_addr,
    input  logic [arc_pkg::CFG_W-1:0]   i_cfg_wr_data
);
    import arc_pkg::*;

    logic [CFG_W-1:0]      r_read_length;
    logic [CFG_W-1:0]      r_cutoff;

    logic [COUNT_BITS-1:0] r_cnt, n_cnt, w_base_cnt;
    logic [KIND_W-1:0]     r_head_kind, n_head_kind;
    logic [OPLEN_W-1:0]    r_head_len, n_head_len;
    logic [SUM_BITS-1:0]   r_matched, n_matched, w_base_matched;
    logic [SUM_BITS-1:0]   r_total, n_total, w_base_total;
    logic [SUM_BITS:0]     w_msum, w_tsum;

    logic                  r_s2_vld;
    t_snap                 r_snap;
    logic [SUM_BITS-1:0]   r_s2_matched, r_s2_total;

    logic                  r_o_vld;
    t_result               r_result;
    t_result               w_result;

    logic [FLAGS_W-1:0]    w_flags;
    logic [OPLEN_W-1:0]    w_len;
    logic [KIND_W-1:0]     w_kind;
    logic                  w_first, w_last, w_accept, w_out_adv, w_s2_rdy;

    assign w_flags = i_s_axis_tdata[FLAGS_W-1:0];
    assign w_len   = i_s_axis_tdata[FLAGS_W+OPLEN_W-1:FLAGS_W];
    assign w_kind  = i_s_axis_tuser[KIND_W-1:0];
    assign w_first = i_s_axis_tuser[KIND_W];
    assign w_last  = i_s_axis_tlast;

    assign w_out_adv       = !r_o_vld || i_m_axis_tready;
    assign w_s2_rdy        = !r_s2_vld || w_out_adv;
    assign o_s_axis_tready = w_s2_rdy;
    assign w_accept        = i_s_axis_tvalid && w_s2_rdy;

    // running read state
    always_comb begin
        w_base_cnt     = w_first ? '0 : r_cnt;
        w_base_matched = w_first ? '0 : r_matched;
        w_base_total   = w_first ? '0 : r_total;
        if (w_base_cnt == '0) begin
            n_head_kind = w_kind;
            n_head_len  = w_len;
        end else begin
            n_head_kind = w_first ? '0 : r_head_kind;
            n_head_len  = w_first ? '0 : r_head_len;
        end
        n_cnt = (w_base_cnt == '1) ? w_base_cnt : w_base_cnt + COUNT_BITS'(1);

        w_msum = {1'b0, w_base_matched} + (SUM_BITS+1)'(w_len);
        w_tsum = {1'b0, w_base_total} + (SUM_BITS+1)'(w_len);

        if (w_kind == KIND_M) begin
            n_matched = w_msum[SUM_BITS] ? '1 : w_msum[SUM_BITS-1:0];
        end else begin
            n_matched = w_base_matched;
        end
        if (w_kind == KIND_M || w_kind == KIND_S || w_kind == KIND_H || w_kind == KIND_I) begin
            n_total = w_tsum[SUM_BITS] ? '1 : w_tsum[SUM_BITS-1:0];
        end else begin
            n_total = w_base_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_length <= READ_LENGTH_RST;
            r_cutoff      <= FULL_MAP_CUTOFF_RST;
            r_cnt         <= '0;
            r_head_kind   <= '0;
            r_head_len    <= '0;
            r_matched     <= '0;
            r_total       <= '0;
            r_s2_vld      <= 1'b0;
            r_o_vld       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    REG_READ_LENGTH:     r_read_length <= i_cfg_wr_data;
                    REG_FULL_MAP_CUTOFF: r_cutoff      <= i_cfg_wr_data;
                    default:             ;
                endcase
            end

            if (w_accept) begin
                if (w_last) begin
                    r_cnt       <= '0;
                    r_head_kind <= '0;
                    r_head_len  <= '0;
                    r_matched   <= '0;
                    r_total     <= '0;
                end else begin
                    r_cnt       <= n_cnt;
                    r_head_kind <= n_head_kind;
                    r_head_len  <= n_head_len;
                    r_matched   <= n_matched;
                    r_total     <= n_total;
                end
            end

            if (w_s2_rdy) begin
                r_s2_vld <= w_accept && w_last;
            end
            if (w_out_adv) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    // snapshot and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_snap.flags     <= w_flags;
            r_snap.head_kind <= n_head_kind;
            r_snap.head_len  <= n_head_len;
            r_snap.tail_kind <= w_kind;
            r_snap.tail_len  <= w_len;
            r_snap.single    <= (n_cnt == COUNT_BITS'(1));
            r_snap.multi     <= (n_cnt != COUNT_BITS'(1));
            r_s2_matched     <= n_matched;
            r_s2_total       <= n_total;
        end
        if (w_out_adv && r_s2_vld) begin
            r_result <= w_result;
        end
    end

    arc_classify #(
        .SUM_BITS(SUM_BITS)
    ) u_classify (
        .i_snap        (r_snap),
        .i_matched     (r_s2_matched),
        .i_total       (r_s2_total),
        .i_read_length (r_read_length),
        .i_cutoff      (r_cutoff),
        .o_result      (w_result)
    );

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {2'b00, r_result};

endmodule
